### sv/pwm_timer_channel_allocator_top_assert.svh
// Assertion macros for the PWM timer channel allocator checker.
// Used by ptca_checker.sv; no other dependencies.
`ifndef PWM_TIMER_CHANNEL_ALLOCATOR_TOP_ASSERT_SVH
`define PWM_TIMER_CHANNEL_ALLOCATOR_TOP_ASSERT_SVH

// Clocked property that is switched off while reset is high.
`define PTCA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define PTCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ptca_pkg.sv
// Shared types, codes and channel-to-timer tables of the PWM timer channel allocator.
// No dependencies; imported by pwm_timer_channel_allocator_top, ptca_seq and ptca_timer_regs.
`default_nettype none

package ptca_pkg;

   localparam int NUM_CHANNELS = 28;
   localparam int NUM_TIMERS   = 10;
   localparam int CH_W         = 5;
   localparam int SLOT_W       = 4;
   localparam int PERIOD_W     = 32;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_SET     = 2'd2,
      OP_GET     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NO_FIT = 2'd1,
      ST_SHARED = 2'd2
   } status_type;

   typedef struct packed {
      status_type           status;
      logic [CH_W-1:0]      granted;
      logic [3:0]           timer_num;
      logic [2:0]           chan_in_timer;
      logic [PERIOD_W-1:0]  period;
   } ptca_result_type;

   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic                 set_on;
      logic                 clr_on;
      logic                 set_period;
      logic [PERIOD_W-1:0]  period;
   } ptca_twrite_type;

   typedef struct packed {
      logic                 on;
      logic [PERIOD_W-1:0]  period;
      logic                 eq;
   } ptca_tread_type;

   // Channels 0..15 sit four to a timer, channels 16..27 two to a timer.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [CH_W-1:0] ch);
      if (!ch[4]) begin
         return {2'b00, ch[3:2]};
      end
      return SLOT_W'(4) + {1'b0, ch[3:1]};
   endfunction

   function automatic logic [2:0] output_of(input logic [CH_W-1:0] ch);
      if (!ch[4]) begin
         return {1'b0, ch[1:0]} + 3'd1;
      end
      return {2'b00, ch[0]} + 3'd1;
   endfunction

   function automatic logic [NUM_CHANNELS-1:0] slot_mask(input logic [SLOT_W-1:0] slot);
      logic [NUM_CHANNELS-1:0] m;
      case (slot)
         4'd0:    m = 28'h000000F;
         4'd1:    m = 28'h00000F0;
         4'd2:    m = 28'h0000F00;
         4'd3:    m = 28'h000F000;
         4'd4:    m = 28'h0030000;
         4'd5:    m = 28'h00C0000;
         4'd6:    m = 28'h0300000;
         4'd7:    m = 28'h0C00000;
         4'd8:    m = 28'h3000000;
         4'd9:    m = 28'hC000000;
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [3:0] hw_timer_num(input logic [SLOT_W-1:0] slot);
      logic [3:0] n;
      case (slot)
         4'd0:    n = 4'd1;
         4'd1:    n = 4'd3;
         4'd2:    n = 4'd4;
         4'd3:    n = 4'd8;
         4'd4:    n = 4'd9;
         4'd5:    n = 4'd10;
         4'd6:    n = 4'd11;
         4'd7:    n = 4'd12;
         4'd8:    n = 4'd13;
         4'd9:    n = 4'd14;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

### sv/pwm_timer_channel_allocator_top.sv
// PWM timer channel allocator.
// The req channel carries one request per transfer: acquire, release, set period or get
// period. The rsp channel returns exactly one result per request, in request order.
// An acquire scans the allowed free channels one per cycle from channel 0, comparing the
// period of each candidate's timer on a single shared comparator. An acquire passes through
// S_SCAN until it takes a channel or has tried channel 27, then S_FINISH; release, set and
// get pass through S_EXEC and S_FINISH. The result enters the output register at the edge
// that ends S_FINISH, and req_tready rises again in the same cycle, so the block takes a new
// request only once the result of the last one is in the output register.
// Synchronous reset marks all channels free, switches all timers off and clears their
// periods; req_tready is high in the first cycle after reset.
// When the receiver stalls, one finished result waits in the output register while the
// next request is accepted and worked on; that request then holds in its last step
// until the output register frees up.
// Depends on ptca_pkg, ptca_seq and ptca_timer_regs.
`default_nettype none

module pwm_timer_channel_allocator_top
   import ptca_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[1:0], allowed_mask[29:2], period_us[61:30], channel_index[66:62], zero pad
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], granted_channel[6:2], timer_number[10:7], channel_in_timer[13:11],
   // period_out[45:14], zero pad
   output logic [47:0]      rsp_tdata
);

   logic [SLOT_W-1:0]   rd_slot;
   logic [PERIOD_W-1:0] cmp_val;
   ptca_tread_type      tread;
   ptca_twrite_type     twr;
   ptca_result_type     result;
   logic                push;
   logic                slot_free;

   logic                rsp_valid_ff, rsp_valid_in;
   ptca_result_type     rsp_data_ff, rsp_data_in;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   ptca_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (op_type'(req_tdata[1:0])),
      .req_mask   (req_tdata[29:2]),
      .req_period (req_tdata[61:30]),
      .req_index  (req_tdata[66:62]),
      .rd_slot    (rd_slot),
      .cmp_val    (cmp_val),
      .tread      (tread),
      .twr        (twr),
      .result     (result),
      .push       (push),
      .slot_free  (slot_free)
   );

   ptca_timer_regs u_timer_regs (
      .clock   (clock),
      .reset   (reset),
      .rd_slot (rd_slot),
      .cmp_val (cmp_val),
      .twr     (twr),
      .tread   (tread)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_data_ff.period,
                        rsp_data_ff.chan_in_timer,
                        rsp_data_ff.timer_num,
                        rsp_data_ff.granted,
                        rsp_data_ff.status};

endmodule

`default_nettype wire

### sv/ptca_timer_regs.sv
// Per-timer on flags and periods with the shared period comparator.
// Depends on ptca_pkg.
`default_nettype none

module ptca_timer_regs
   import ptca_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [SLOT_W-1:0]    rd_slot,
   input  wire logic [PERIOD_W-1:0]  cmp_val,
   input  wire ptca_twrite_type      twr,
   output ptca_tread_type            tread
);

   logic                on_ff     [NUM_TIMERS];
   logic [PERIOD_W-1:0] period_ff [NUM_TIMERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TIMERS; t++) begin
            on_ff[t]     <= 1'b0;
            period_ff[t] <= '0;
         end
      end else begin
         if (twr.set_on) begin
            on_ff[twr.slot] <= 1'b1;
         end else if (twr.clr_on) begin
            on_ff[twr.slot] <= 1'b0;
         end
         if (twr.set_period) begin
            period_ff[twr.slot] <= twr.period;
         end
      end
   end

   always_comb begin
      tread.on     = on_ff[rd_slot];
      tread.period = period_ff[rd_slot];
      tread.eq     = (period_ff[rd_slot] == cmp_val);
   end

endmodule

`default_nettype wire

### sv/ptca_seq.sv
// Request sequencer of the PWM timer channel allocator: free map, channel scan and updates.
// Depends on ptca_pkg; drives ptca_timer_regs.
`default_nettype none

module ptca_seq
   import ptca_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire op_type                   req_op,
   input  wire logic [NUM_CHANNELS-1:0]  req_mask,
   input  wire logic [PERIOD_W-1:0]      req_period,
   input  wire logic [CH_W-1:0]          req_index,
   output logic [SLOT_W-1:0]             rd_slot,
   output logic [PERIOD_W-1:0]           cmp_val,
   input  wire ptca_tread_type           tread,
   output ptca_twrite_type               twr,
   output ptca_result_type               result,
   output logic                          push,
   input  wire logic                     slot_free
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_EXEC   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [CH_W-1:0]         cnt_ff, cnt_in;
   op_type                  op_ff, op_in;
   logic [NUM_CHANNELS-1:0] avail_ff, avail_in;
   logic [PERIOD_W-1:0]     period_ff, period_in;
   logic [CH_W-1:0]         idx_ff, idx_in;
   logic [NUM_CHANNELS-1:0] free_ff, free_in;
   ptca_result_type         result_ff, result_in;

   logic                    idx_valid;
   logic [NUM_CHANNELS-1:0] bit_v;
   logic [NUM_CHANNELS-1:0] all_v;

   assign req_ready = (state_ff == S_IDLE);
   assign idx_valid = (idx_ff < CH_W'(NUM_CHANNELS));
   assign bit_v     = NUM_CHANNELS'(1) << idx_ff;
   assign all_v     = slot_mask(rd_slot);
   assign cmp_val   = period_ff;
   assign result    = result_ff;

   always_comb begin
      if (state_ff == S_SCAN) begin
         rd_slot = slot_of(cnt_ff);
      end else if (idx_valid) begin
         rd_slot = slot_of(idx_ff);
      end else begin
         rd_slot = '0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      op_in          = op_ff;
      avail_in       = avail_ff;
      period_in      = period_ff;
      idx_in         = idx_ff;
      free_in        = free_ff;
      result_in      = result_ff;
      push           = 1'b0;
      twr.slot       = rd_slot;
      twr.set_on     = 1'b0;
      twr.clr_on     = 1'b0;
      twr.set_period = 1'b0;
      twr.period     = period_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               avail_in  = req_mask & free_ff;
               period_in = req_period;
               idx_in    = req_index;
               cnt_in    = '0;
               state_in  = (req_op == OP_ACQUIRE) ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            if (avail_ff[cnt_ff] && (!tread.on || tread.eq)) begin
               free_in = free_ff & ~(NUM_CHANNELS'(1) << cnt_ff);
               if (!tread.on) begin
                  twr.set_on     = 1'b1;
                  twr.set_period = 1'b1;
               end
               result_in.status        = ST_OK;
               result_in.granted       = cnt_ff;
               result_in.timer_num     = hw_timer_num(rd_slot);
               result_in.chan_in_timer = output_of(cnt_ff);
               result_in.period        = period_ff;
               state_in                = S_FINISH;
            end else if (cnt_ff == CH_W'(NUM_CHANNELS - 1)) begin
               result_in.status        = ST_NO_FIT;
               result_in.granted       = idx_ff;
               result_in.timer_num     = '0;
               result_in.chan_in_timer = '0;
               result_in.period        = '0;
               state_in                = S_FINISH;
            end else begin
               cnt_in = cnt_ff + CH_W'(1);
            end
         end
         S_EXEC: begin
            result_in.status        = ST_NO_FIT;
            result_in.granted       = idx_ff;
            result_in.timer_num     = '0;
            result_in.chan_in_timer = '0;
            result_in.period        = '0;
            if (idx_valid) begin
               result_in.status = ST_OK;
               result_in.period = tread.period;
               case (op_ff)
                  OP_RELEASE: begin
                     free_in = free_ff | bit_v;
                     if (((free_ff | bit_v) & all_v) == all_v) begin
                        twr.clr_on = 1'b1;
                     end
                  end
                  OP_SET: begin
                     if ((free_ff & all_v) == (all_v & ~bit_v)) begin
                        twr.set_period   = 1'b1;
                        result_in.period = period_ff;
                     end else begin
                        result_in.status = ST_SHARED;
                     end
                  end
                  default: begin
                  end
               endcase
               if (result_in.status == ST_OK) begin
                  result_in.timer_num     = hw_timer_num(rd_slot);
                  result_in.chan_in_timer = output_of(idx_ff);
               end
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '1;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      op_ff     <= op_in;
      avail_ff  <= avail_in;
      period_ff <= period_in;
      idx_ff    <= idx_in;
      result_ff <= result_in;
   end

endmodule

`default_nettype wire

### sv/ptca_checker.sv
// Port-level checker for the PWM timer channel allocator, bound to the top level.
// Depends on pwm_timer_channel_allocator_top_assert.svh.
`default_nettype none

`include "pwm_timer_channel_allocator_top_assert.svh"

module ptca_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // The block works on one request at a time.
   `PTCA_ASSERT(busy_after_req, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "request taken while busy")

   `PTCA_ASSERT(rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result changed")

   `PTCA_ASSERT(fail_fields_zero, clock, reset, (rsp_tvalid && rsp_tdata[1:0] != 2'd0) |-> (rsp_tdata[13:7] == 7'd0), "failed result carries a timer")

   `PTCA_ASSERT(status_code, clock, reset, rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3), "undefined status code")

   `PTCA_ASSERT_ALWAYS(reset_idle, clock, reset |=> (req_tready && !rsp_tvalid), "block not idle after reset")

endmodule

bind pwm_timer_channel_allocator_top ptca_checker u_ptca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
